@@ rtl/sms_pkg.sv @@
package sms_pkg;

    localparam int MAX_ROWS = 64;
    localparam int MAX_COLS = 64;

    localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int ADDR_W = ROW_W + COL_W;
    localparam int DATA_W = 32;
    localparam int CNT_W  = 7;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;

    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_USED = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_USED = 1'b1;

    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_SEARCH = 1'b1;

    typedef struct packed {
        logic               func;
        logic [5:0]         row_index;
        logic [5:0]         col_index;
        logic signed [31:0] value;
    } in_item_t;

    typedef struct packed {
        logic       found;
        logic [6:0] hit_row;
        logic [6:0] hit_col;
    } out_item_t;

    typedef struct packed {
        logic [CNT_W-1:0] rows_used;
        logic [CNT_W-1:0] cols_used;
    } cfg_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [DATA_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } mem_req_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DONE
    } walk_state_t;

endpackage

@@ rtl/sms_ram.sv @@
module sms_ram #(
    parameter int ADDR_W = 12,
    parameter int DATA_W = 32
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [2**ADDR_W];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/sms_walk.sv @@
module sms_walk
    import sms_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  in_item_t          in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output out_item_t         out_data,
    input  cfg_t              cfg,
    output mem_req_t          mem_req,
    input  logic [DATA_W-1:0] mem_rdata
);

    walk_state_t state_reg, state_next;

    logic [ROW_W-1:0]   row_reg, row_next;
    logic [COL_W-1:0]   col_reg, col_next;
    logic [CNT_W-1:0]   nrows_reg, nrows_next;
    logic signed [31:0] key_reg, key_next;
    out_item_t          res_reg, res_next;
    logic               out_valid_reg, out_valid_next;
    out_item_t          out_data_reg, out_data_next;

    logic [CNT_W-1:0]   nrows_sat;
    logic [CNT_W-1:0]   ncols_sat;
    logic signed [31:0] elem;
    logic [CNT_W-1:0]   row_inc;
    logic               accept;
    logic               out_free;

    assign nrows_sat = (cfg.rows_used > CNT_W'(MAX_ROWS)) ? CNT_W'(MAX_ROWS) : cfg.rows_used;
    assign ncols_sat = (cfg.cols_used > CNT_W'(MAX_COLS)) ? CNT_W'(MAX_COLS) : cfg.cols_used;
    assign elem      = $signed(mem_rdata);
    assign row_inc   = CNT_W'(row_reg) + CNT_W'(1);
    assign accept    = in_valid && (state_reg == ST_IDLE);
    assign out_free  = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next     = state_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        nrows_next     = nrows_reg;
        key_next       = key_reg;
        res_next       = res_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && out_stall;
        mem_req        = '0;
        in_stall       = (state_reg != ST_IDLE);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_data.func == FUNC_LOAD)
                    begin
                        // loads outside the store are dropped
                        if (int'(in_data.row_index) < MAX_ROWS &&
                            int'(in_data.col_index) < MAX_COLS)
                        begin
                            mem_req.we    = 1'b1;
                            mem_req.waddr = {ROW_W'(in_data.row_index),
                                             COL_W'(in_data.col_index)};
                            mem_req.wdata = in_data.value;
                        end
                    end
                    else
                    begin
                        res_next   = '0;
                        key_next   = in_data.value;
                        nrows_next = nrows_sat;
                        row_next   = '0;
                        col_next   = COL_W'(ncols_sat - CNT_W'(1));
                        if (nrows_sat == '0 || ncols_sat == '0)
                        begin
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            // start at the top-right corner
                            mem_req.re    = 1'b1;
                            mem_req.raddr = {ROW_W'(0), COL_W'(ncols_sat - CNT_W'(1))};
                            state_next    = ST_WALK;
                        end
                    end
                end
            end

            ST_WALK:
            begin
                if (key_reg == elem)
                begin
                    res_next.found   = 1'b1;
                    res_next.hit_row = row_inc;
                    res_next.hit_col = CNT_W'(col_reg) + CNT_W'(1);
                    state_next       = ST_DONE;
                end
                else if (key_reg > elem)
                begin
                    if (row_inc == nrows_reg)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        row_next      = ROW_W'(row_inc);
                        mem_req.re    = 1'b1;
                        mem_req.raddr = {ROW_W'(row_inc), col_reg};
                    end
                end
                else
                begin
                    if (col_reg == '0)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        col_next      = col_reg - COL_W'(1);
                        mem_req.re    = 1'b1;
                        mem_req.raddr = {row_reg, col_reg - COL_W'(1)};
                    end
                end
            end

            ST_DONE:
            begin
                if (out_free)
                begin
                    out_data_next  = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg      <= row_next;
        col_reg      <= col_next;
        nrows_reg    <= nrows_next;
        key_reg      <= key_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

@@ rtl/sorted_matrix_saddleback_search.sv @@
// Saddleback search over a matrix of signed 32-bit values, 64 x 64 entries held in one
// synchronous memory. A load item (func 0) writes one element and gives no result; loads are
// taken on consecutive cycles while no search is in progress. A search item (func 1) walks from
// the top-right corner of the used region, one memory read and compare per cycle, moving down
// when the key is larger and left when it is smaller, and gives one result: the 1-based row and
// column of the match, or all zeros. A search stalls the input until its result has moved from
// the done state into the output register, and the done state waits while a held result is
// stalled. An empty used region goes to the done state without a memory read. rows_used and
// cols_used reset to 64, saturate at 64, and the user must see that they are written through the
// config port only while idle; the block itself does not enforce this. The contents of the memory
// are undefined until loaded, and every entry that a search may touch must have been loaded first.
module sorted_matrix_saddleback_search
    import sms_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  in_item_t              in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output out_item_t             out_data,
    input  logic                  cfg_en,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t              cfg_reg;
    mem_req_t          mem_req;
    logic [DATA_W-1:0] mem_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rows_used <= CNT_W'(64);
            cfg_reg.cols_used <= CNT_W'(64);
        end
        else if (cfg_en)
        begin
            unique case (cfg_addr)
                CFG_ROWS_USED: cfg_reg.rows_used <= CNT_W'(cfg_data);
                CFG_COLS_USED: cfg_reg.cols_used <= CNT_W'(cfg_data);
                default:       cfg_reg           <= cfg_reg;
            endcase
        end
    end

    sms_walk u_walk (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg       (cfg_reg),
        .mem_req   (mem_req),
        .mem_rdata (mem_rdata)
    );

    sms_ram #(
        .ADDR_W (ADDR_W),
        .DATA_W (DATA_W)
    ) u_ram (
        .clk   (clk),
        .we    (mem_req.we),
        .waddr (mem_req.waddr),
        .wdata (mem_req.wdata),
        .re    (mem_req.re),
        .raddr (mem_req.raddr),
        .rdata (mem_rdata)
    );

endmodule

@@ rtl/sms_checker.sv @@
module sms_checker
    import sms_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_stall,
    input in_item_t              in_data,
    input logic                  out_valid,
    input logic                  out_stall,
    input out_item_t             out_data
);

    // a miss reports no position
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.found |-> out_data.hit_row == '0 && out_data.hit_col == '0)
        else $error("miss result carries a position");

    // a hit lies inside the store
    a_hit_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.found |->
            out_data.hit_row != '0 && out_data.hit_col != '0 &&
            int'(out_data.hit_row) <= MAX_ROWS && int'(out_data.hit_col) <= MAX_COLS)
        else $error("hit position out of range");

    // a search keeps the block busy on the following cycle
    a_search_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && in_data.func == FUNC_SEARCH |=> in_stall)
        else $error("search item did not occupy the block");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

endmodule

bind sorted_matrix_saddleback_search sms_checker u_sms_checker (.*);

@@ tb/sorted_matrix_saddleback_search_tb.sv @@
`timescale 1ns / 1ps

module sorted_matrix_saddleback_search_tb;
    import sms_pkg::*;

    localparam int TOTAL_ITEMS     = 700;
    localparam int SETTLE_CYCLES   = MAX_ROWS + MAX_COLS + 8;
    localparam int WATCHDOG_CYCLES = 5000;
    localparam int SQUEEZE_CYCLES  = 600;
    localparam int SQUEEZE_PHASE   = 8;
    localparam longint INT_LO      = -64'sd2147483648;
    localparam longint INT_HI      = 64'sd2147483647;

    class search_tracker;
        logic signed [31:0] cells [MAX_ROWS][MAX_COLS];
        int unsigned rows_set;
        int unsigned cols_set;
        out_item_t pending_hits[$];
        int mismatches;
        int loads_seen;
        int searches_seen;
        int hits_seen;

        function new();
            rows_set = MAX_ROWS;
            cols_set = MAX_COLS;
            mismatches = 0;
            loads_seen = 0;
            searches_seen = 0;
            hits_seen = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            if (idx == CFG_ROWS_USED)
                rows_set = val;
            else if (idx == CFG_COLS_USED)
                cols_set = val;
        endfunction

        // walk from the top-right corner of the used region
        function out_item_t walk_from_corner(logic signed [31:0] key);
            out_item_t res;
            int nr;
            int nc;
            int r;
            int c;
            bit stop;
            res = '0;
            nr = (rows_set > MAX_ROWS) ? MAX_ROWS : rows_set;
            nc = (cols_set > MAX_COLS) ? MAX_COLS : cols_set;
            if (nr == 0 || nc == 0)
                return res;
            r = 0;
            c = nc - 1;
            stop = 1'b0;
            while (r < nr && !stop)
            begin
                if (key == cells[r][c])
                begin
                    res.found = 1'b1;
                    res.hit_row = 7'(r + 1);
                    res.hit_col = 7'(c + 1);
                    stop = 1'b1;
                end
                else if (key > cells[r][c])
                    r++;
                else if (c == 0)
                    stop = 1'b1;
                else
                    c--;
            end
            return res;
        endfunction

        function void note_input(in_item_t it);
            if (it.func == FUNC_LOAD)
            begin
                cells[it.row_index][it.col_index] = it.value;
                loads_seen++;
            end
            else
            begin
                pending_hits.push_back(walk_from_corner(it.value));
                searches_seen++;
            end
        endfunction

        function void compare_field(string field, logic [6:0] want, logic [6:0] got);
            if (got !== want)
            begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (pending_hits.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual found=%0d row=%0d col=%0d",
                         $time, got.found, got.hit_row, got.hit_col);
                mismatches++;
                return;
            end
            want = pending_hits.pop_front();
            if (want.found)
                hits_seen++;
            compare_field("found", 7'(want.found), 7'(got.found));
            compare_field("hit_row", want.hit_row, got.hit_row);
            compare_field("hit_col", want.hit_col, got.hit_col);
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    in_item_t in_data = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    out_item_t out_data;
    logic cfg_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_addr = CFG_ROWS_USED;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    logic steady = 1'b0;
    logic squeeze_req = 1'b0;
    logic signed [31:0] grid [MAX_ROWS][MAX_COLS];
    search_tracker tracker;

    sorted_matrix_saddleback_search DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_en    (cfg_en),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int pick_gap();
        int sel;
        sel = $urandom_range(0, 99);
        if (steady)
            return 0;
        if (sel < 55)
            return 0;
        if (sel < 85)
            return $urandom_range(1, 3);
        if (sel < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [31:0] pick_key(int nr, int nc);
        int sel;
        int r;
        int c;
        sel = $urandom_range(0, 99);
        if (nr == 0 || nc == 0)
            return $signed($urandom);
        r = $urandom_range(0, nr - 1);
        c = $urandom_range(0, nc - 1);
        if (sel < 55)
            return grid[r][c];
        if (sel < 70)
            return grid[r][c] + 1;
        if (sel < 85)
            return grid[r][c] - 1;
        if (sel < 90)
            return 32'sh8000_0000;
        if (sel < 95)
            return 32'sh7fff_ffff;
        return $signed($urandom);
    endfunction

    function automatic in_item_t search_item(logic signed [31:0] key);
        in_item_t it;
        it.func = FUNC_SEARCH;
        it.row_index = 6'($urandom_range(0, 63));
        it.col_index = 6'($urandom_range(0, 63));
        it.value = key;
        return it;
    endfunction

    task automatic send_item(in_item_t it);
        int gap;
        gap = pick_gap();
        repeat (gap)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_data <= it;
        do
            @(posedge clk);
        while (in_stall);
        tracker.note_input(it);
    endtask

    task automatic send_load(int r, int c, logic signed [31:0] v);
        in_item_t it;
        it.func = FUNC_LOAD;
        it.row_index = 6'(r);
        it.col_index = 6'(c);
        it.value = v;
        grid[r][c] = v;
        send_item(it);
    endtask

    // strictly ascending top row and last column, enough for walks that stay on them
    task automatic fill_edges();
        longint acc;
        acc = INT_LO + 1;
        for (int c = 0; c < MAX_COLS; c++)
        begin
            acc += $urandom_range(1, 33554432);
            send_load(0, c, 32'(acc));
        end
        for (int r = 1; r < MAX_ROWS; r++)
        begin
            acc += $urandom_range(1, 33554432);
            send_load(r, MAX_COLS - 1, 32'(acc));
        end
    endtask

    // sorted unless scrambled: each entry is the larger of its upper and left neighbors plus a step
    task automatic fill_region(int nr, int nc, longint base, int unsigned step_max,
                               bit scrambled);
        longint acc;
        for (int r = 0; r < nr; r++)
            for (int c = 0; c < nc; c++)
            begin
                if (scrambled)
                    acc = longint'($signed($urandom));
                else if (r == 0 && c == 0)
                    acc = base;
                else
                begin
                    if (r == 0)
                        acc = grid[r][c-1];
                    else if (c == 0)
                        acc = grid[r-1][c];
                    else
                        acc = (grid[r-1][c] > grid[r][c-1]) ? grid[r-1][c] : grid[r][c-1];
                    acc += $urandom_range(0, step_max);
                    if (acc > INT_HI)
                        acc = INT_HI;
                end
                send_load(r, c, 32'(acc));
            end
    endtask

    task automatic random_item(int nr, int nc);
        if ($urandom_range(0, 99) < 8)
            send_load($urandom_range(0, 63), $urandom_range(0, 63), $signed($urandom));
        else
            send_item(search_item(pick_key(nr, nc)));
    endtask

    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (tracker.pending_hits.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_sizes(logic [CFG_DATA_W-1:0] rows_val,
                               logic [CFG_DATA_W-1:0] cols_val);
        @(negedge clk);
        cfg_en <= 1'b1;
        cfg_addr <= CFG_ROWS_USED;
        cfg_data <= rows_val;
        @(negedge clk);
        cfg_addr <= CFG_COLS_USED;
        cfg_data <= cols_val;
        tracker.set_reg(CFG_ROWS_USED, rows_val);
        @(negedge clk);
        cfg_en <= 1'b0;
        tracker.set_reg(CFG_COLS_USED, cols_val);
    endtask

    initial
    begin : stimulus
        logic signed [31:0] probes [14];
        int rows_list [9];
        int cols_list [9];
        int steps [6];
        int rows_val;
        int cols_val;
        int nr;
        int nc;
        int n;
        int phase;
        longint base;
        tracker = new();
        rows_list = '{1, 1, 64, 0, 6, 0, 127, 1, 4};
        cols_list = '{1, 64, 1, 5, 0, 0, 1, 127, 4};
        steps = '{0, 1, 3, 100, 65536, 67108864};
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        // reset sizes, with walks along the top row and down the last column
        fill_edges();
        probes = '{32'sh8000_0000, 32'sh7fff_ffff, grid[0][0], grid[0][63], grid[63][63],
                   grid[0][31], grid[40][63], grid[0][1], grid[62][63], grid[0][0] - 1,
                   grid[63][63] + 1, grid[1][63], grid[0][62], grid[32][63]};
        foreach (probes[i])
            send_item(search_item(probes[i]));

        phase = 0;
        while (tracker.loads_seen + tracker.searches_seen < TOTAL_ITEMS)
        begin
            if (phase < 9)
            begin
                rows_val = rows_list[phase];
                cols_val = cols_list[phase];
            end
            else if ($urandom_range(0, 4) == 0)
            begin
                rows_val = $urandom_range(1, 12);
                cols_val = $urandom_range(1, 12);
            end
            else
            begin
                rows_val = $urandom_range(1, 8);
                cols_val = $urandom_range(1, 8);
            end
            nr = (rows_val > MAX_ROWS) ? MAX_ROWS : rows_val;
            nc = (cols_val > MAX_COLS) ? MAX_COLS : cols_val;
            base = ($urandom_range(0, 3) == 0) ? INT_LO : longint'($signed($urandom));
            settle();
            write_sizes(7'(rows_val), 7'(cols_val));
            steady = ($urandom_range(0, 3) == 0);
            fill_region(nr, nc, base, steps[$urandom_range(0, 5)], (phase % 5) == 4);
            if (phase == SQUEEZE_PHASE)
                squeeze_req = 1'b1;
            n = $urandom_range(15, 35);
            repeat (n) random_item(nr, nc);
            phase++;
        end

        settle();
        $display("run covered %0d loads and %0d searches (%0d hits) over %0d size settings,",
                 tracker.loads_seen, tracker.searches_seen, tracker.hits_seen, phase + 1);
        $display("including empty, single-entry, full-height, full-width, saturated and unsorted");
        if (tracker.mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin : drain_side
        int n;
        forever
        begin
            @(negedge clk);
            if (squeeze_req)
            begin
                squeeze_req = 1'b0;
                out_stall <= 1'b1;
                repeat (SQUEEZE_CYCLES) @(negedge clk);
            end
            else
            begin
                n = pick_gap();
                if (n == 0)
                    out_stall <= 1'b0;
                else
                begin
                    out_stall <= 1'b1;
                    repeat (n - 1) @(negedge clk);
                end
            end
        end
    end

    initial
    begin : result_side
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
                tracker.check_result(out_data);
        end
    end

    initial
    begin : watchdog
        int stuck;
        stuck = 0;
        while (stuck < WATCHDOG_CYCLES)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                stuck = 0;
            else
                stuck++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
